@@ rtl/i2c_mbe_pkg.sv @@
// shared types and constants of the i2c master byte engine
package i2c_mbe_pkg;

  typedef enum logic [2:0] {
    ActStart   = 3'd0,
    ActStop    = 3'd1,
    ActWrite   = 3'd2,
    ActRead    = 3'd3,
    ActWaitAck = 3'd4,
    ActAck     = 3'd5,
    ActNack    = 3'd6,
    ActProbe   = 3'd7
  } action_e;

  typedef struct packed {
    logic    cmd;
    action_e act;
    logic [7:0] tx;
    logic    sda;
  } item_t;

  localparam logic [4:0]  StepIdle      = 5'd31;
  localparam logic [15:0] PhaseTicksRst = 16'd10;

endpackage

@@ rtl/i2c_mbe_front.sv @@
// input stage: takes items from the input channel and registers them for the queue
module i2c_mbe_front import i2c_mbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_valid_i,
  input  logic [2:0] action_i,
  input  logic [7:0] tx_byte_i,
  input  logic       sda_in_i,
  output logic       push_o,
  output item_t      item_o,
  input  logic       q_ready_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_ready_o = !valid_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d     = 1'b1;
      item_d.cmd  = cmd_valid_i;
      item_d.act  = action_e'(action_i);
      item_d.tx   = tx_byte_i;
      item_d.sda  = sda_in_i;
    end else if (q_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_o = valid_q;
  assign item_o = item_q;

endmodule

@@ rtl/i2c_mbe_queue.sv @@
// short item queue between the input stage and the bus sequencer
module i2c_mbe_queue import i2c_mbe_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  item_t           mem [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign ready_o = (count_q != CntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem[rd_ptr_q];
  assign push    = push_i && ready_o;
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QDepth))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && !pop) |=> valid_o)
    else $error("queue empty after push");

endmodule

@@ rtl/i2c_mbe_back.sv @@
// bus sequencer: runs command phases one tick per item and registers the result
module i2c_mbe_back import i2c_mbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        nack_o
);

  localparam logic [1:0] GrpDelay = 2'd0;
  localparam logic [1:0] GrpLast  = 2'd1;
  localparam logic [1:0] GrpNone  = 2'd2;

  typedef struct packed {
    logic [4:0] step;
    action_e    act;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic [7:0] rx;
    logic       ack;
    logic       scl;
    logic       sda;
    logic [1:0] stage;
  } seq_t;

  typedef struct packed {
    seq_t       st;
    logic [1:0] res;
  } grp_t;

  function automatic action_e sub_cmd(seq_t s);
    action_e a;
    a = s.act;
    if (s.act == ActProbe) begin
      unique case (s.stage)
        2'd0:    a = ActStart;
        2'd1:    a = ActWrite;
        2'd2:    a = ActWaitAck;
        default: a = ActStop;
      endcase
    end
    return a;
  endfunction

  function automatic grp_t run_group(seq_t s_in, action_e sub, logic sda);
    grp_t r;
    seq_t s;
    s = s_in;
    r.res = GrpDelay;
    unique case (sub)
      ActStart: begin
        if (s.step == 5'd0) begin
          s.sda = 1'b1; s.scl = 1'b1; s.step = 5'd1;
        end else if (s.step == 5'd1) begin
          s.sda = 1'b0; s.step = 5'd2;
        end else if (s.step == 5'd2) begin
          s.scl = 1'b0; s.step = 5'd3;
        end else begin
          r.res = GrpNone;
        end
      end
      ActStop: begin
        if (s.step == 5'd0) begin
          s.sda = 1'b0; s.scl = 1'b1; s.step = 5'd1;
        end else begin
          s.sda = 1'b1; r.res = GrpLast;
        end
      end
      ActWrite: begin
        if (s.bit_idx[3]) begin
          r.res = GrpNone;
        end else if (s.step == 5'd0) begin
          s.sda = s.shift[7]; s.step = 5'd1;
        end else if (s.step == 5'd1) begin
          s.scl = 1'b1; s.step = 5'd2;
        end else begin
          s.scl = 1'b0;
          if (s.bit_idx == 4'd7) begin
            s.sda = 1'b1;
          end
          s.shift   = {s.shift[6:0], 1'b0};
          s.step    = 5'd0;
          s.bit_idx = s.bit_idx + 4'd1;
        end
      end
      ActRead: begin
        if (s.bit_idx[3]) begin
          s.rx = s.shift; r.res = GrpNone;
        end else if (s.step == 5'd0) begin
          s.scl = 1'b1; s.sda = 1'b1; s.step = 5'd1;
        end else begin
          s.shift   = {s.shift[6:0], sda};
          s.scl     = 1'b0;
          s.step    = 5'd0;
          s.bit_idx = s.bit_idx + 4'd1;
        end
      end
      ActAck: begin
        if (s.step == 5'd0) begin
          s.sda = 1'b0; s.step = 5'd1;
        end else if (s.step == 5'd1) begin
          s.scl = 1'b1; s.step = 5'd2;
        end else if (s.step == 5'd2) begin
          s.scl = 1'b0; s.step = 5'd3;
        end else begin
          s.sda = 1'b1; r.res = GrpLast;
        end
      end
      default: begin
        if (s.step == 5'd0) begin
          s.sda = 1'b1; s.step = 5'd1;
        end else if (s.step == 5'd1) begin
          s.scl = 1'b1; s.step = 5'd2;
        end else if (s.step == 5'd2) begin
          if (sub == ActWaitAck) begin
            s.ack = sda;
          end
          s.scl = 1'b0; s.step = 5'd3;
        end else begin
          r.res = GrpNone;
        end
      end
    endcase
    r.st = s;
    return r;
  endfunction

  logic [15:0] phase_ticks_q, phase_len;
  logic [15:0] timer_q, timer_d;
  seq_t        seq_q, seq_d, pre, mid;
  grp_t        g1, g2;
  logic        idle, do_adv, done;
  logic        out_valid_q, out_valid_d;
  logic        scl_q, sda_q, busy_q, done_q, ack_q;
  logic [7:0]  rx_q;

  assign pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign idle      = (seq_q.step == StepIdle);
  assign phase_len = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;

  always_comb begin
    pre     = seq_q;
    do_adv  = 1'b0;
    timer_d = timer_q;
    if (idle) begin
      if (q_item_i.cmd) begin
        pre.act     = q_item_i.act;
        pre.shift   = q_item_i.tx;
        pre.step    = 5'd0;
        pre.bit_idx = '0;
        pre.stage   = '0;
        do_adv      = 1'b1;
      end
    end else if (timer_q > 16'd1) begin
      timer_d = timer_q - 16'd1;
    end else begin
      do_adv = 1'b1;
    end

    g1          = run_group(pre, sub_cmd(pre), q_item_i.sda);
    mid         = g1.st;
    mid.stage   = g1.st.stage + 2'd1;
    mid.step    = 5'd0;
    mid.bit_idx = '0;
    g2          = run_group(mid, sub_cmd(mid), q_item_i.sda);

    seq_d = seq_q;
    done  = 1'b0;
    if (do_adv) begin
      if (g1.res == GrpDelay) begin
        seq_d   = g1.st;
        timer_d = phase_len;
      end else if (pre.act == ActProbe && pre.stage != 2'd3) begin
        seq_d = g2.st;
        if (g2.res == GrpDelay) begin
          timer_d = phase_len;
        end else begin
          seq_d.step = StepIdle;
          timer_d    = '0;
          done       = 1'b1;
        end
      end else begin
        seq_d      = g1.st;
        seq_d.step = StepIdle;
        timer_d    = '0;
        done       = 1'b1;
      end
    end

    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
      timer_q       <= '0;
      seq_q         <= '{step: StepIdle, act: ActStart, scl: 1'b1, sda: 1'b1, default: '0};
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        timer_q <= timer_d;
        seq_q   <= seq_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      scl_q  <= seq_d.scl;
      sda_q  <= seq_d.sda;
      busy_q <= (seq_d.step != StepIdle);
      done_q <= done;
      rx_q   <= seq_d.rx;
      ack_q  <= seq_d.ack;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_q;
  assign nack_o      = ack_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> !busy_q)
    else $error("done reported while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle == (timer_q == '0))
    else $error("phase timer out of step with sequencer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !idle && timer_q > 16'd1) |=> ($stable(seq_q.scl) && $stable(seq_q.sda)))
    else $error("bus levels changed during a hold");

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// top level of the i2c master byte engine
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------------
// input    | in_valid_i/in_ready_o  | cmd_valid_i action_i tx_byte_i sda_in_i
// output   | out_valid_o/out_ready_i| scl_out_o sda_out_o busy_res_o done_res_o
//          |                        | rx_byte_o nack_o
// config   | cfg_we_i               | cfg_wdata_i (phase length in ticks)
//
// one item per cycle unless the output stalls; each item is one bus tick, one result
// a result passes the input stage, the queue and the output register in turn
// the sequencer advances one tick per item, a probe chaining two phases
// reset is asynchronous, no clearing pass; the phase length resets to 10 ticks
// either side may stall on its own; the queue absorbs QDepth items between them
module i2c_master_byte_engine import i2c_mbe_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        nack_o
);

  logic  push, q_ready, q_valid, pop;
  item_t f_item, q_item;

  i2c_mbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_valid_i (cmd_valid_i),
    .action_i    (action_i),
    .tx_byte_i   (tx_byte_i),
    .sda_in_i    (sda_in_i),
    .push_o      (push),
    .item_o      (f_item),
    .q_ready_i   (q_ready)
  );

  i2c_mbe_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  i2c_mbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .nack_o      (nack_o)
  );

endmodule

@@ test/i2c_master_byte_engine_tb.sv @@
// self-checking testbench of the i2c master byte engine: predicted bus drive per item
module i2c_master_byte_engine_tb import i2c_mbe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } bus_drive_t;

  typedef enum logic [1:0] {PhHold, PhLast, PhNone} phase_end_e;
  typedef enum logic [1:0] {SdaLow, SdaHigh, SdaRandom} sda_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_valid_i = 1'b0;
  logic [2:0]  action_i = '0;
  logic [7:0]  tx_byte_i = '0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        nack_o;

  i2c_master_byte_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_valid_i (cmd_valid_i),
    .action_i    (action_i),
    .tx_byte_i   (tx_byte_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .nack_o      (nack_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sequencer state as the block should hold it
  logic [15:0] phase_len;
  logic [4:0]  seq_step;
  action_e     cur_act;
  logic [15:0] hold_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [7:0]  rx_last;
  logic        ack_bit;
  logic        scl_lvl;
  logic        sda_lvl;
  logic [1:0]  probe_idx;

  bus_drive_t drive_q[$];
  bus_drive_t want_r;
  bus_drive_t got_r;
  int         fault_cnt = 0;
  int         ticks_sent = 0;
  bit         gaps_on = 1'b1;

  function automatic void reset_model();
    phase_len = PhaseTicksRst;
    seq_step  = StepIdle;
    cur_act   = ActStart;
    hold_cnt  = '0;
    bit_cnt   = '0;
    shifter   = '0;
    rx_last   = '0;
    ack_bit   = 1'b0;
    scl_lvl   = 1'b1;
    sda_lvl   = 1'b1;
    probe_idx = '0;
  endfunction

  function automatic action_e sub_action();
    if (cur_act != ActProbe) return cur_act;
    case (probe_idx)
      2'd0: return ActStart;
      2'd1: return ActWrite;
      2'd2: return ActWaitAck;
      default: return ActStop;
    endcase
  endfunction

  function automatic phase_end_e run_phase(action_e sub, logic sda);
    phase_end_e res;
    res = PhHold;
    case (sub)
      ActStart: begin
        if (seq_step == 0) begin
          sda_lvl = 1'b1;
          scl_lvl = 1'b1;
        end else if (seq_step == 1) begin
          sda_lvl = 1'b0;
        end else if (seq_step == 2) begin
          scl_lvl = 1'b0;
        end else begin
          res = PhNone;
        end
        if (res == PhHold) seq_step++;
      end
      ActStop: begin
        if (seq_step == 0) begin
          sda_lvl  = 1'b0;
          scl_lvl  = 1'b1;
          seq_step = 5'd1;
        end else begin
          sda_lvl = 1'b1;
          res     = PhLast;
        end
      end
      ActWrite: begin
        if (bit_cnt >= 8) begin
          res = PhNone;
        end else if (seq_step == 0) begin
          sda_lvl  = shifter[7];
          seq_step = 5'd1;
        end else if (seq_step == 1) begin
          scl_lvl  = 1'b1;
          seq_step = 5'd2;
        end else begin
          scl_lvl = 1'b0;
          if (bit_cnt == 7) sda_lvl = 1'b1;
          shifter  = {shifter[6:0], 1'b0};
          seq_step = 5'd0;
          bit_cnt++;
        end
      end
      ActRead: begin
        if (bit_cnt >= 8) begin
          rx_last = shifter;
          res     = PhNone;
        end else if (seq_step == 0) begin
          scl_lvl  = 1'b1;
          sda_lvl  = 1'b1;
          seq_step = 5'd1;
        end else begin
          shifter  = {shifter[6:0], sda};
          scl_lvl  = 1'b0;
          seq_step = 5'd0;
          bit_cnt++;
        end
      end
      ActAck: begin
        if (seq_step == 0) begin
          sda_lvl = 1'b0;
        end else if (seq_step == 1) begin
          scl_lvl = 1'b1;
        end else if (seq_step == 2) begin
          scl_lvl = 1'b0;
        end else begin
          sda_lvl = 1'b1;
          res     = PhLast;
        end
        if (res == PhHold) seq_step++;
      end
      default: begin
        // wait ack and nack clock one bit with sda released
        if (seq_step == 0) begin
          sda_lvl = 1'b1;
        end else if (seq_step == 1) begin
          scl_lvl = 1'b1;
        end else if (seq_step == 2) begin
          if (sub == ActWaitAck) ack_bit = sda;
          scl_lvl = 1'b0;
        end else begin
          res = PhNone;
        end
        if (res == PhHold) seq_step++;
      end
    endcase
    return res;
  endfunction

  function automatic logic run_until_hold(logic sda);
    phase_end_e res;
    logic       held;
    logic       fin;
    held = 1'b0;
    fin  = 1'b0;
    while (!held && !fin) begin
      res = run_phase(sub_action(), sda);
      if (res == PhHold) begin
        hold_cnt = (phase_len == 0) ? 16'd1 : phase_len;
        held     = 1'b1;
      end else if (cur_act == ActProbe && probe_idx < 3) begin
        probe_idx++;
        seq_step = 5'd0;
        bit_cnt  = 4'd0;
      end else begin
        seq_step = StepIdle;
        hold_cnt = '0;
        fin      = 1'b1;
      end
    end
    return fin;
  endfunction

  function automatic bus_drive_t bus_tick(logic cmd, action_e act, logic [7:0] tx, logic sda);
    bus_drive_t res;
    logic       fin;
    fin = 1'b0;
    if (seq_step == StepIdle) begin
      if (cmd) begin
        cur_act   = act;
        shifter   = tx;
        seq_step  = 5'd0;
        bit_cnt   = 4'd0;
        probe_idx = 2'd0;
        fin       = run_until_hold(sda);
      end
    end else if (hold_cnt > 1) begin
      hold_cnt = hold_cnt - 16'd1;
    end else begin
      fin = run_until_hold(sda);
    end
    res.scl  = scl_lvl;
    res.sda  = sda_lvl;
    res.busy = (seq_step != StepIdle);
    res.done = fin;
    res.rx   = rx_last;
    res.nack = ack_bit;
    return res;
  endfunction

  function automatic logic pick_sda(sda_mode_e mode);
    case (mode)
      SdaLow: return 1'b0;
      SdaHigh: return 1'b1;
      default: return 1'($urandom);
    endcase
  endfunction

  function automatic action_e any_action();
    return action_e'(3'($urandom));
  endfunction

  task automatic send_tick(input logic cmd, input action_e act, input logic [7:0] tx,
                           input logic sda);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_valid_i <= cmd;
    action_i    <= act;
    tx_byte_i   <= tx;
    sda_in_i    <= sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    drive_q.push_back(bus_tick(cmd, act, tx, sda));
    ticks_sent++;
  endtask

  // idle ticks until the command is over, with ignored commands mixed in
  task automatic finish_command(input sda_mode_e mode, input int noise);
    while (seq_step != StepIdle) begin
      send_tick(noise != 0 && $urandom_range(1, noise) == 1, any_action(), 8'($urandom),
                pick_sda(mode));
    end
  endtask

  task automatic issue(input action_e act, input logic [7:0] tx, input sda_mode_e mode,
                       input int noise);
    send_tick(1'b1, act, tx, pick_sda(mode));
    finish_command(mode, noise);
  endtask

  task automatic wait_results();
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_phase_len(input logic [15:0] ticks);
    finish_command(SdaRandom, 0);
    in_valid_i <= 1'b0;
    wait_results();
    repeat (5) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    phase_len = ticks;
  endtask

  task automatic run_transaction();
    int kind;
    int nbytes;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      issue(ActStart, 8'($urandom), SdaRandom, 12);
      issue(ActWrite, 8'($urandom), SdaRandom, 12);
      issue(ActWaitAck, 8'($urandom), ($urandom_range(0, 3) == 0) ? SdaHigh : SdaLow, 12);
      nbytes = $urandom_range(1, 3);
      for (int k = 0; k < nbytes; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          issue(ActWrite, 8'($urandom), SdaRandom, 12);
          issue(ActWaitAck, 8'($urandom), SdaRandom, 12);
        end else begin
          issue(ActRead, 8'($urandom), SdaRandom, 12);
          issue((k == nbytes - 1) ? ActNack : ActAck, 8'($urandom), SdaRandom, 12);
        end
      end
      issue(ActStop, 8'($urandom), SdaRandom, 12);
    end else if (kind <= 7) begin
      issue(ActProbe, 8'($urandom), ($urandom_range(0, 2) == 0) ? SdaHigh : SdaLow, 12);
    end else if (kind == 8) begin
      issue(any_action(), 8'($urandom), SdaRandom, 6);
    end else begin
      repeat ($urandom_range(1, 6)) send_tick(1'b0, any_action(), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_reset_phase();
    issue(ActStart, 8'h80, SdaRandom, 0);
    issue(ActStop, 8'h7F, SdaRandom, 0);
  endtask

  task automatic test_each_action();
    set_phase_len(16'd1);
    issue(ActStart, 8'h00, SdaLow, 0);
    issue(ActWrite, 8'hFF, SdaLow, 0);
    issue(ActWaitAck, 8'h00, SdaLow, 0);
    issue(ActWrite, 8'h00, SdaHigh, 0);
    issue(ActWaitAck, 8'hFF, SdaHigh, 0);
    issue(ActRead, 8'h00, SdaHigh, 0);
    issue(ActAck, 8'h00, SdaLow, 0);
    issue(ActRead, 8'hFF, SdaLow, 0);
    issue(ActNack, 8'h00, SdaHigh, 0);
    issue(ActRead, 8'hA5, SdaRandom, 0);
    issue(ActStop, 8'h00, SdaLow, 0);
    issue(ActProbe, 8'hA0, SdaLow, 0);
    issue(ActProbe, 8'h5F, SdaHigh, 0);
  endtask

  task automatic test_zero_phase();
    set_phase_len(16'd0);
    issue(ActWrite, 8'h5A, SdaRandom, 0);
    issue(ActRead, 8'h00, SdaRandom, 0);
    issue(ActProbe, 8'h01, SdaHigh, 0);
  endtask

  // a command on every tick, so some land on busy and completion ticks
  task automatic test_busy_commands();
    set_phase_len(16'd2);
    repeat (60) send_tick(1'b1, any_action(), 8'($urandom), 1'($urandom));
    finish_command(SdaRandom, 0);
  endtask

  task automatic test_longest_phase();
    gaps_on = 1'b0;
    set_phase_len(16'h0100);
    issue(ActStop, 8'hC3, SdaRandom, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_bus_traffic();
    int first;
    first = ticks_sent;
    while (ticks_sent - first < 900) begin
      set_phase_len(16'($urandom_range(0, 4)));
      for (int k = 0; k < 8 && ticks_sent - first < 900; k++) run_transaction();
    end
  endtask

  task automatic test_steady_flow();
    int first;
    gaps_on = 1'b0;
    set_phase_len(16'd1);
    first = ticks_sent;
    while (ticks_sent - first < 300) run_transaction();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_r = {scl_out_o, sda_out_o, busy_res_o, done_res_o, rx_byte_o, nack_o};
      if (drive_q.size() == 0) begin
        if (fault_cnt < 10) begin
          $display("unexpected result: scl %0b sda %0b busy %0b done %0b rx %02h nack %0b",
                   got_r.scl, got_r.sda, got_r.busy, got_r.done, got_r.rx, got_r.nack);
        end
        fault_cnt++;
      end else begin
        want_r = drive_q.pop_front();
        if (got_r !== want_r) begin
          if (fault_cnt < 10) begin
            $display("mismatch expected: scl %0b sda %0b busy %0b done %0b rx %02h nack %0b",
                     want_r.scl, want_r.sda, want_r.busy, want_r.done, want_r.rx, want_r.nack);
            $display("         actual:   scl %0b sda %0b busy %0b done %0b rx %02h nack %0b",
                     got_r.scl, got_r.sda, got_r.busy, got_r.done, got_r.rx, got_r.nack);
          end
          fault_cnt++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (gaps_on ? $urandom_range(1, 20) : 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_phase();
    test_each_action();
    test_zero_phase();
    test_busy_commands();
    test_longest_phase();
    test_bus_traffic();
    test_steady_flow();
    in_valid_i <= 1'b0;
    wait_results();
    repeat (10) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
